[src/utf8dat_pkg.sv]
// Shared types and constants of the double at-sign trigger detector.
`default_nettype none
package utf8dat_pkg;

    localparam int unsigned CP_W      = 21;
    localparam int unsigned BYTE_W    = 8;
    localparam int unsigned ACT_W     = 2;
    localparam int unsigned CFG_IDX_W = 1;

    localparam logic [CP_W-1:0] REPL_CP     = 21'h00FFFD;
    localparam logic [CP_W-1:0] AT_CODE_RST = 21'd64;
    localparam logic [CP_W-1:0] AT_ALT_RST  = 21'd65312;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_AT_CODE = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_AT_ALT  = 1'b1;

    // opcode field codes
    localparam logic OPC_KEY  = 1'b0;
    localparam logic OPC_TEXT = 1'b1;

    // UTF-8 byte classes
    localparam logic [BYTE_W-1:0] ASCII_LIMIT = 8'h80;
    localparam logic [BYTE_W-1:0] LEAD2_MASK  = 8'hE0;
    localparam logic [BYTE_W-1:0] LEAD2_VAL   = 8'hC0;
    localparam logic [BYTE_W-1:0] LEAD3_MASK  = 8'hF0;
    localparam logic [BYTE_W-1:0] LEAD3_VAL   = 8'hE0;
    localparam logic [BYTE_W-1:0] LEAD4_MASK  = 8'hF8;
    localparam logic [BYTE_W-1:0] LEAD4_VAL   = 8'hF0;
    localparam logic [BYTE_W-1:0] CONT_MASK   = 8'hC0;
    localparam logic [BYTE_W-1:0] CONT_VAL    = 8'h80;
    localparam logic [BYTE_W-1:0] CONT_PAY    = 8'h3F;
    localparam logic [BYTE_W-1:0] LEAD2_PAY   = 8'h1F;
    localparam logic [BYTE_W-1:0] LEAD3_PAY   = 8'h0F;
    localparam logic [BYTE_W-1:0] LEAD4_PAY   = 8'h07;

    typedef enum logic [ACT_W-1:0] {
        ACT_CONT   = 2'd0,
        ACT_IGNORE = 2'd1,
        ACT_FIRE   = 2'd2
    } t_action;

    typedef enum logic [1:0] {
        OP_SECURE,
        OP_COMPOSE,
        OP_KEY,
        OP_BYTE
    } t_kind;

    typedef struct packed {
        t_kind             kind;
        logic [BYTE_W-1:0] text_byte;
        logic              last_byte;
    } t_cmd;

    typedef enum logic {
        ST_RUN,
        ST_REPLAY
    } t_back_state;

endpackage
`default_nettype wire

[src/utf8dat_in_if.sv]
// Input channel: key events and committed text bytes.
`default_nettype none
interface utf8dat_in_if;
    logic       valid;
    logic       ready;
    logic       opcode;
    logic       secure_field;
    logic       composing;
    logic [7:0] text_byte;
    logic       last_byte;

    modport source (output valid, output opcode, output secure_field, output composing,
                    output text_byte, output last_byte, input ready);
    modport sink   (input valid, input opcode, input secure_field, input composing,
                    input text_byte, input last_byte, output ready);
endinterface
`default_nettype wire

[src/utf8dat_out_if.sv]
// Output channel: one action per event or commit end.
`default_nettype none
interface utf8dat_out_if;
    logic       valid;
    logic       ready;
    logic [1:0] action;

    modport source (output valid, output action, input ready);
    modport sink   (input valid, input action, output ready);
endinterface
`default_nettype wire

[src/utf8dat_front.sv]
// Front end: accepts input transfers, classifies them and queues commands.
`default_nettype none
module utf8dat_front #(
    parameter int unsigned DEPTH = 2
) (
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    utf8dat_in_if.sink        i_in,
    output utf8dat_pkg::t_cmd o_cmd,
    output logic              o_cmd_valid,
    input  wire logic         i_cmd_pop
);
    import utf8dat_pkg::*;

    localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CNT_W = $clog2(DEPTH + 1);

    t_cmd             r_q [0:DEPTH-1];
    logic [PTR_W-1:0] r_wptr, n_wptr;
    logic [PTR_W-1:0] r_rptr, n_rptr;
    logic [CNT_W-1:0] r_cnt, n_cnt;
    t_cmd             cls;
    logic             push, pop;

    // priority: secure, then composing, then key event, then text byte
    always_comb begin
        cls.text_byte = i_in.text_byte;
        cls.last_byte = i_in.last_byte;
        if (i_in.secure_field) begin
            cls.kind = OP_SECURE;
        end else if (i_in.composing) begin
            cls.kind = OP_COMPOSE;
        end else if (i_in.opcode == OPC_KEY) begin
            cls.kind = OP_KEY;
        end else begin
            cls.kind = OP_BYTE;
        end
    end

    assign i_in.ready  = (r_cnt != CNT_W'(DEPTH));
    assign push        = i_in.valid && i_in.ready;
    assign pop         = i_cmd_pop && (r_cnt != '0);
    assign o_cmd_valid = (r_cnt != '0);
    assign o_cmd       = r_q[r_rptr];

    always_comb begin
        n_wptr = r_wptr;
        n_rptr = r_rptr;
        n_cnt  = r_cnt;
        if (push) begin
            n_wptr = (r_wptr == PTR_W'(DEPTH - 1)) ? '0 : r_wptr + 1'b1;
        end
        if (pop) begin
            n_rptr = (r_rptr == PTR_W'(DEPTH - 1)) ? '0 : r_rptr + 1'b1;
        end
        if (push && !pop) begin
            n_cnt = r_cnt + 1'b1;
        end else if (pop && !push) begin
            n_cnt = r_cnt - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr <= '0;
            r_rptr <= '0;
            r_cnt  <= '0;
        end else begin
            r_wptr <= n_wptr;
            r_rptr <= n_rptr;
            r_cnt  <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_q[r_wptr] <= cls;
        end
    end

endmodule
`default_nettype wire

[src/utf8dat_back.sv]
// Back end: UTF-8 decode, replay of held span bytes, at-sign history and result register.
`default_nettype none
module utf8dat_back (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire utf8dat_pkg::t_cmd              i_cmd,
    input  wire logic                           i_cmd_valid,
    output logic                                o_cmd_pop,
    input  wire logic [utf8dat_pkg::CP_W-1:0]   i_at_code,
    input  wire logic [utf8dat_pkg::CP_W-1:0]   i_at_alt_code,
    utf8dat_out_if.source                       o_out
);
    import utf8dat_pkg::*;

    // shift one character into the two-entry history; bit 0 is the older entry
    function automatic logic [3:0] f_push(input logic [1:0] hist, input logic [1:0] fill,
                                          input logic [CP_W-1:0] cp,
                                          input logic [CP_W-1:0] at_a,
                                          input logic [CP_W-1:0] at_b);
        logic [1:0] h;
        logic [1:0] f;
        logic       flag;
        h    = hist;
        f    = fill;
        flag = (cp == at_a) || (cp == at_b);
        if (cp != '0) begin
            case (fill)
                2'd0: begin
                    h[0] = flag;
                    f    = 2'd1;
                end
                2'd1: begin
                    h[1] = flag;
                    f    = 2'd2;
                end
                default: begin
                    h[0] = h[1];
                    h[1] = flag;
                    f    = 2'd2;
                end
            endcase
        end
        return {f, h};
    endfunction

    t_back_state       r_state, n_state;
    logic [1:0]        r_hist, n_hist;
    logic [1:0]        r_fill, n_fill;
    logic [BYTE_W-1:0] r_held [0:2];
    logic [BYTE_W-1:0] n_held [0:2];
    logic [1:0]        r_held_cnt, n_held_cnt;
    logic [1:0]        r_span, n_span;
    logic [CP_W-1:0]   r_acc, n_acc;
    logic [BYTE_W-1:0] r_rep [0:1];
    logic [BYTE_W-1:0] n_rep [0:1];
    logic [1:0]        r_rep_cnt, n_rep_cnt;
    logic              r_rep_last, n_rep_last;
    logic              r_out_valid, n_out_valid;
    t_action           r_out_action, n_out_action;

    logic              out_free;
    logic              go;
    logic [BYTE_W-1:0] b;
    logic              last_src;
    logic [1:0]        rem_cnt;
    logic [1:0]        cnt_inc;
    logic [BYTE_W-1:0] c [0:2];
    logic              found;
    logic [1:0]        bad_j;
    logic [CP_W-1:0]   acc_w;
    logic              push_v;
    logic [CP_W-1:0]   push_cp;
    logic [1:0]        tail_cnt;
    logic [BYTE_W-1:0] tail [0:1];
    logic [3:0]        ph;

    assign out_free = !r_out_valid || o_out.ready;
    assign go = out_free && ((r_state == ST_REPLAY) || i_cmd_valid);
    assign b = (r_state == ST_REPLAY) ? r_rep[0] : i_cmd.text_byte;
    assign last_src = (r_state == ST_REPLAY) ? r_rep_last : i_cmd.last_byte;
    assign rem_cnt = (r_state == ST_REPLAY) ? r_rep_cnt - 2'd1 : 2'd0;
    assign cnt_inc = r_held_cnt + 2'd1;
    assign o_cmd_pop = go && (r_state == ST_RUN);
    assign o_out.valid = r_out_valid;
    assign o_out.action = r_out_action;

    // bytes of a completing span: held ones, then the current byte
    always_comb begin
        for (int j = 0; j < 3; j++) begin
            if (2'(j) < r_held_cnt) begin
                c[j] = r_held[j];
            end else if (2'(j) == r_held_cnt) begin
                c[j] = b;
            end else begin
                c[j] = '0;
            end
        end
    end

    always_comb begin
        found = 1'b0;
        bad_j = 2'd0;
        acc_w = r_acc;
        for (int j = 0; j < 3; j++) begin
            if ((2'(j) < r_span) && !found) begin
                if ((c[j] & CONT_MASK) != CONT_VAL) begin
                    found = 1'b1;
                    bad_j = 2'(j);
                end else begin
                    acc_w = {acc_w[CP_W-7:0], c[j][5:0]};
                end
            end
        end
    end

    always_comb begin
        n_state      = r_state;
        n_hist       = r_hist;
        n_fill       = r_fill;
        n_held       = r_held;
        n_held_cnt   = r_held_cnt;
        n_span       = r_span;
        n_acc        = r_acc;
        n_rep        = r_rep;
        n_rep_cnt    = r_rep_cnt;
        n_rep_last   = r_rep_last;
        n_out_valid  = r_out_valid && !o_out.ready;
        n_out_action = r_out_action;
        push_v       = 1'b0;
        push_cp      = '0;
        tail_cnt     = 2'd0;
        tail[0]      = '0;
        tail[1]      = '0;
        ph           = {r_fill, r_hist};

        if (go && (r_state == ST_RUN) && (i_cmd.kind != OP_BYTE)) begin
            n_out_valid = 1'b1;
            unique case (i_cmd.kind)
                OP_SECURE: begin
                    n_hist       = '0;
                    n_fill       = '0;
                    n_span       = '0;
                    n_held_cnt   = '0;
                    n_acc        = '0;
                    n_out_action = ACT_IGNORE;
                end
                OP_COMPOSE: n_out_action = ACT_IGNORE;
                default:    n_out_action = ACT_CONT;
            endcase
        end else if (go) begin
            // one byte through the decoder
            if (r_span == 2'd0) begin
                if (b < ASCII_LIMIT) begin
                    push_v  = 1'b1;
                    push_cp = CP_W'(b);
                end else if ((b & LEAD2_MASK) == LEAD2_VAL) begin
                    n_span     = 2'd1;
                    n_held_cnt = 2'd0;
                    n_acc      = CP_W'(b & LEAD2_PAY);
                end else if ((b & LEAD3_MASK) == LEAD3_VAL) begin
                    n_span     = 2'd2;
                    n_held_cnt = 2'd0;
                    n_acc      = CP_W'(b & LEAD3_PAY);
                end else if ((b & LEAD4_MASK) == LEAD4_VAL) begin
                    n_span     = 2'd3;
                    n_held_cnt = 2'd0;
                    n_acc      = CP_W'(b & LEAD4_PAY);
                end else begin
                    push_v  = 1'b1;
                    push_cp = REPL_CP;
                end
            end else begin
                case (r_held_cnt)
                    2'd0:    n_held[0] = b;
                    2'd1:    n_held[1] = b;
                    2'd2:    n_held[2] = b;
                    default: ;
                endcase
                if (cnt_inc == r_span) begin
                    n_span     = '0;
                    n_held_cnt = '0;
                    n_acc      = '0;
                    push_v     = 1'b1;
                    if (found) begin
                        push_cp  = REPL_CP;
                        // bytes after the bad one go round again as new leads
                        tail_cnt = r_span - 2'd1 - bad_j;
                        case (bad_j)
                            2'd0: begin
                                tail[0] = c[1];
                                tail[1] = c[2];
                            end
                            2'd1:    tail[0] = c[2];
                            default: ;
                        endcase
                    end else begin
                        push_cp = acc_w;
                    end
                end else begin
                    n_held_cnt = cnt_inc;
                end
            end

            if (push_v) begin
                ph = f_push(r_hist, r_fill, push_cp, i_at_code, i_at_alt_code);
            end

            if (tail_cnt != 2'd0) begin
                n_state    = ST_REPLAY;
                n_rep[0]   = tail[0];
                n_rep[1]   = tail[1];
                n_rep_cnt  = tail_cnt;
                n_rep_last = last_src;
            end else if (rem_cnt != 2'd0) begin
                n_state   = ST_REPLAY;
                n_rep[0]  = r_rep[1];
                n_rep_cnt = rem_cnt;
            end else begin
                n_state   = ST_RUN;
                n_rep_cnt = '0;
                if (last_src) begin
                    // commit end: an open span collapses into one replacement
                    if (n_span != 2'd0) begin
                        n_span     = '0;
                        n_held_cnt = '0;
                        n_acc      = '0;
                        ph = f_push(ph[1:0], ph[3:2], REPL_CP, i_at_code, i_at_alt_code);
                    end
                    n_out_valid = 1'b1;
                    if ((ph[3:2] == 2'd2) && (ph[1:0] == 2'b11)) begin
                        ph           = '0;
                        n_out_action = ACT_FIRE;
                    end else begin
                        n_out_action = ACT_CONT;
                    end
                end
            end
            n_fill = ph[3:2];
            n_hist = ph[1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_RUN;
            r_hist      <= '0;
            r_fill      <= '0;
            r_held_cnt  <= '0;
            r_span      <= '0;
            r_acc       <= '0;
            r_rep_cnt   <= '0;
            r_rep_last  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_hist      <= n_hist;
            r_fill      <= n_fill;
            r_held_cnt  <= n_held_cnt;
            r_span      <= n_span;
            r_acc       <= n_acc;
            r_rep_cnt   <= n_rep_cnt;
            r_rep_last  <= n_rep_last;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_held       <= n_held;
        r_rep        <= n_rep;
        r_out_action <= n_out_action;
    end

endmodule
`default_nettype wire

[src/utf8_double_at_trigger_detector_unit.sv]
// Top level of the double at-sign trigger detector.
// A result passes through the command queue and then the result register.
// Throughput: one item per cycle while the result register is not stalled; a bad
// continuation byte pauses queue pops while its left-over span bytes replay (at most two).
// Reset (synchronous, active low) empties the queue, history, open span and result
// register and restores at_code to 64 and at_alt_code to 65312; held bytes keep junk.
`default_nettype none
module utf8_double_at_trigger_detector_unit #(
    parameter int unsigned QUEUE_DEPTH = 2   // command queue between front and back
) (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    utf8dat_in_if.sink                               i_in,
    utf8dat_out_if.source                            o_out,
    input  wire logic                                i_cfg_we,
    input  wire logic [utf8dat_pkg::CFG_IDX_W-1:0]   i_cfg_idx,
    input  wire logic [utf8dat_pkg::CP_W-1:0]        i_cfg_data
);
    import utf8dat_pkg::*;

    logic [CP_W-1:0] r_at_code;
    logic [CP_W-1:0] r_at_alt;
    t_cmd            cmd;
    logic            cmd_valid;
    logic            cmd_pop;

    // Configuration registers: the user must write them only while the block is quiet (the
    // block itself does not enforce this), so the back end sees them as constants during any commit.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_at_code <= AT_CODE_RST;
            r_at_alt  <= AT_ALT_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_AT_CODE: r_at_code <= i_cfg_data;
                CFG_AT_ALT:  r_at_alt  <= i_cfg_data;
            endcase
        end
    end

    // Front: takes every transfer while the queue has room and tags it as
    // secure, composing, key event or text byte.
    utf8dat_front #(
        .DEPTH (QUEUE_DEPTH)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in        (i_in),
        .o_cmd       (cmd),
        .o_cmd_valid (cmd_valid),
        .i_cmd_pop   (cmd_pop)
    );

    // Back: decodes bytes, replays span bytes after a bad continuation,
    // keeps the two-character at-sign history and holds the result until taken.
    utf8dat_back u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (cmd),
        .i_cmd_valid   (cmd_valid),
        .o_cmd_pop     (cmd_pop),
        .i_at_code     (r_at_code),
        .i_at_alt_code (r_at_alt),
        .o_out         (o_out)
    );

endmodule
`default_nettype wire

[tb/tb_utf8_double_at_trigger_detector_unit.sv]
// Self-checking testbench of the double at-sign trigger detector: random UTF-8 commits vs predictor.
`default_nettype none
module tb_utf8_double_at_trigger_detector_unit;
    timeunit 1ns;
    timeprecision 1ps;

    import utf8dat_pkg::*;

    localparam int CLK_HALF       = 4;
    localparam int RESET_CYCLES   = 6;
    localparam int SETTLE_CYCLES  = 10;   // command queue and result register plus replay of held bytes
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int PHASE_ITEMS    = 575;

    // One input transfer as the block sees it.
    typedef struct packed {
        logic              opcode;
        logic              secure;
        logic              compose;
        logic [BYTE_W-1:0] tbyte;
        logic              last;
    } t_input_item;

    logic                 i_clk = 1'b0;
    logic                 i_rst_n;
    logic                 i_cfg_we;
    logic [CFG_IDX_W-1:0] i_cfg_idx;
    logic [CP_W-1:0]      i_cfg_data;

    utf8dat_in_if  in_if ();
    utf8dat_out_if out_if ();

    utf8_double_at_trigger_detector_unit i_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in       (in_if),
        .o_out      (out_if),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data)
    );

    always #CLK_HALF i_clk = ~i_clk;

    // ------------------------------------------------------------------
    // Predictor state: a private copy of the detector's history, open span
    // and registers, advanced on every accepted input transfer.
    // ------------------------------------------------------------------
    logic              at_hist [2];        // entry 0 is the older character
    logic [1:0]        hist_fill;
    logic [7:0]        held [3];           // continuation bytes of the open span
    logic [1:0]        held_cnt;
    logic [1:0]        span_len;           // zero when no span is open
    logic [CP_W-1:0]   dec_acc;
    logic [CP_W-1:0]   cfg_at;
    logic [CP_W-1:0]   cfg_alt;

    // Stimulus and scoreboard.
    t_input_item       pending_items [$];
    t_action           expected_actions [$];
    logic [7:0]        commit_bytes [$];   // commit under construction
    logic [CP_W-1:0]   gen_at;             // codes the generator treats as at-signs
    logic [CP_W-1:0]   gen_alt;
    int                tx_idle_pct;
    int                rx_idle_pct;
    int                items_queued;
    int                items_sent;
    int                result_count;
    int                fire_count;
    int                error_count;
    int                stall_cycles;
    bit                in_fire;
    bit                out_fire;
    bit                has_result;
    t_action           act;
    t_input_item       seen;
    t_input_item       next_item;

    function automatic void clear_hist();
        at_hist[0] = 1'b0;
        at_hist[1] = 1'b0;
        hist_fill  = 2'd0;
    endfunction

    function automatic void clear_span();
        span_len = 2'd0;
        held_cnt = 2'd0;
        dec_acc  = '0;
    endfunction

    function automatic void reset_predictor();
        cfg_at  = AT_CODE_RST;
        cfg_alt = AT_ALT_RST;
        clear_hist();
        clear_span();
        held[0] = '0;
        held[1] = '0;
        held[2] = '0;
    endfunction

    // Shift one decoded character into the at-sign history; NUL never counts.
    function automatic void shift_char(input logic [CP_W-1:0] cp);
        logic flag;
        if (cp == '0) return;
        flag = (cp == cfg_at) || (cp == cfg_alt);
        case (hist_fill)
            2'd0: begin
                at_hist[0] = flag;
                hist_fill  = 2'd1;
            end
            2'd1: begin
                at_hist[1] = flag;
                hist_fill  = 2'd2;
            end
            default: begin
                at_hist[0] = at_hist[1];
                at_hist[1] = flag;
            end
        endcase
    endfunction

    function automatic void open_span(input logic [1:0] len, input logic [CP_W-1:0] bits);
        span_len = len;
        held_cnt = 2'd0;
        dec_acc  = bits;
    endfunction

    // Decode one committed byte. A bad continuation byte is consumed as U+FFFD and the
    // span bytes behind it go back to the head of the work list as fresh lead bytes.
    function automatic void feed_text_byte(input logic [7:0] first);
        logic [7:0]      work [$];
        logic [7:0]      b;
        logic [7:0]      span_bytes [3];
        logic [CP_W-1:0] acc;
        int              k;
        int              j;
        int              m;
        bit              bad;
        work.push_front(first);
        while (work.size() != 0) begin
            b = work.pop_front();
            if (span_len == 2'd0) begin
                if (b < ASCII_LIMIT)
                    shift_char(CP_W'(b));
                else if ((b & LEAD2_MASK) == LEAD2_VAL)
                    open_span(2'd1, CP_W'(b & LEAD2_PAY));
                else if ((b & LEAD3_MASK) == LEAD3_VAL)
                    open_span(2'd2, CP_W'(b & LEAD3_PAY));
                else if ((b & LEAD4_MASK) == LEAD4_VAL)
                    open_span(2'd3, CP_W'(b & LEAD4_PAY));
                else
                    shift_char(REPL_CP);
            end else begin
                held[held_cnt] = b;
                held_cnt = held_cnt + 2'd1;
                if (held_cnt == span_len) begin
                    k          = int'(span_len);
                    span_bytes = held;
                    acc        = dec_acc;
                    clear_span();
                    bad = 1'b0;
                    for (j = 0; j < k; j++) begin
                        if (!bad) begin
                            if ((span_bytes[j] & CONT_MASK) != CONT_VAL) begin
                                shift_char(REPL_CP);
                                bad = 1'b1;
                                for (m = k - 1; m > j; m--)
                                    work.push_front(span_bytes[m]);
                            end else begin
                                acc = {acc[CP_W-7:0], span_bytes[j][5:0]};
                            end
                        end
                    end
                    if (!bad) shift_char(acc);
                end
            end
        end
    endfunction

    // Expected action of one accepted transfer; a text byte that does not end its
    // commit gives no result.
    function automatic void predict_action(input t_input_item it, output bit produces,
                                           output t_action action);
        produces = 1'b1;
        action   = ACT_CONT;
        if (it.secure) begin
            clear_hist();
            clear_span();
            action = ACT_IGNORE;
        end else if (it.compose) begin
            action = ACT_IGNORE;
        end else if (it.opcode == OPC_TEXT) begin
            feed_text_byte(it.tbyte);
            if (!it.last) begin
                produces = 1'b0;
            end else begin
                // a span still open at the commit end collapses into one U+FFFD
                if (span_len != 2'd0) begin
                    clear_span();
                    shift_char(REPL_CP);
                end
                if (hist_fill == 2'd2 && at_hist[0] && at_hist[1]) begin
                    clear_hist();
                    action = ACT_FIRE;
                end
            end
        end
    endfunction

    // ------------------------------------------------------------------
    // Monitor: samples both channels and the register port at the rising edge,
    // predicts on each input transfer and checks each output transfer.
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            reset_predictor();
            in_fire      = 1'b0;
            out_fire     = 1'b0;
            stall_cycles = 0;
        end else begin
            in_fire  = in_if.valid && in_if.ready;
            out_fire = out_if.valid && out_if.ready;
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_AT_CODE: cfg_at  = i_cfg_data;
                    CFG_AT_ALT:  cfg_alt = i_cfg_data;
                    default: ;
                endcase
            end
            if (in_fire) begin
                seen.opcode  = in_if.opcode;
                seen.secure  = in_if.secure_field;
                seen.compose = in_if.composing;
                seen.tbyte   = in_if.text_byte;
                seen.last    = in_if.last_byte;
                predict_action(seen, has_result, act);
                items_sent++;
                if (has_result) expected_actions.insert(expected_actions.size(), act);
            end
            if (out_fire) begin
                result_count++;
                if (expected_actions.size() == 0) begin
                    error_count++;
                    $display("%0t: result with nothing expected: expected none, actual %0d",
                             $time, out_if.action);
                end else begin
                    act = expected_actions.pop_front();
                    if (out_if.action !== act) begin
                        error_count++;
                        $display("%0t: action mismatch: expected %0d, actual %0d",
                                 $time, act, out_if.action);
                    end else if (act == ACT_FIRE) begin
                        fire_count++;
                    end
                end
            end
            // watchdog: any transfer or register write counts as progress
            if (in_fire || out_fire || i_cfg_we)
                stall_cycles = 0;
            else
                stall_cycles++;
            if (stall_cycles >= WATCHDOG_LIMIT) begin
                $display("%0t: no transfer for %0d cycles, %0d results still awaited",
                         $time, WATCHDOG_LIMIT, expected_actions.size());
                $display("*** FAILED ***");
                $finish;
            end
        end
    end

    // ------------------------------------------------------------------
    // Driver: moves inputs at the falling edge. valid holds until the monitor
    // has seen the transfer; ready is drawn afresh every cycle.
    // ------------------------------------------------------------------
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            in_if.valid  <= 1'b0;
            out_if.ready <= 1'b0;
        end else begin
            out_if.ready <= ($urandom_range(99) >= rx_idle_pct);
            if (!in_if.valid || in_fire) begin
                if (pending_items.size() != 0 && $urandom_range(99) >= tx_idle_pct) begin
                    next_item = pending_items.pop_front();
                    in_if.valid        <= 1'b1;
                    in_if.opcode       <= next_item.opcode;
                    in_if.secure_field <= next_item.secure;
                    in_if.composing    <= next_item.compose;
                    in_if.text_byte    <= next_item.tbyte;
                    in_if.last_byte    <= next_item.last;
                end else begin
                    in_if.valid <= 1'b0;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Stimulus helpers.
    // ------------------------------------------------------------------
    task automatic queue_item(input logic opc, input logic sec, input logic comp,
                              input logic [7:0] data, input logic lst);
        t_input_item it;
        it.opcode  = opc;
        it.secure  = sec;
        it.compose = comp;
        it.tbyte   = data;
        it.last    = lst;
        pending_items.insert(pending_items.size(), it);
        items_queued++;
    endtask

    task automatic queue_text(input logic [7:0] data, input logic lst);
        queue_item(OPC_TEXT, 1'b0, 1'b0, data, lst);
    endtask

    // Append one byte to the commit under construction.
    task automatic add_byte(input logic [7:0] data);
        commit_bytes.insert(commit_bytes.size(), data);
    endtask

    function automatic int utf8_len(input logic [CP_W-1:0] cp);
        if (cp < 21'h80)    return 1;
        if (cp < 21'h800)   return 2;
        if (cp < 21'h10000) return 3;
        return 4;
    endfunction

    // Encode cp in n bytes; n above the minimum gives an overlong form.
    task automatic append_utf8(input logic [CP_W-1:0] cp, input int n);
        case (n)
            1: add_byte({1'b0, cp[6:0]});
            2: begin
                add_byte({3'b110, cp[10:6]});
                add_byte({2'b10, cp[5:0]});
            end
            3: begin
                add_byte({4'b1110, cp[15:12]});
                add_byte({2'b10, cp[11:6]});
                add_byte({2'b10, cp[5:0]});
            end
            default: begin
                add_byte({5'b11110, cp[20:18]});
                add_byte({2'b10, cp[17:12]});
                add_byte({2'b10, cp[11:6]});
                add_byte({2'b10, cp[5:0]});
            end
        endcase
    endtask

    function automatic logic [CP_W-1:0] random_cp(input int n);
        if (n == 2) return CP_W'($urandom_range(21'h7FF, 21'h80));
        if (n == 3) return CP_W'($urandom_range(21'hFFFF, 21'h800));
        return CP_W'($urandom_range(21'h1FFFFF, 21'h10000));
    endfunction

    // One character of a commit: mostly at-signs, some plain text, some damage.
    task automatic append_random_char();
        int              pick;
        int              n;
        int              cut;
        logic [CP_W-1:0] cp;
        pick = $urandom_range(99);
        if (pick < 60) begin
            cp = (pick < 42) ? gen_at : gen_alt;
            n  = utf8_len(cp);
            if ($urandom_range(9) == 0) n = $urandom_range(4, n);
            append_utf8(cp, n);
        end else if (pick < 72) begin
            append_utf8(CP_W'($urandom_range(8'h7F, 8'h01)), 1);
        end else if (pick < 82) begin
            n = $urandom_range(4, 2);
            append_utf8(random_cp(n), n);
        end else if (pick < 86) begin
            // NUL or an overlong zero, both skipped
            append_utf8('0, $urandom_range(4, 1));
        end else if (pick < 90) begin
            // stray continuation byte or a lead byte that UTF-8 never uses
            if ($urandom_range(1))
                add_byte(8'($urandom_range(8'hBF, 8'h80)));
            else
                add_byte(8'($urandom_range(8'hFF, 8'hF8)));
        end else if (pick < 95) begin
            // span with one continuation byte replaced by a non-continuation byte
            n = $urandom_range(4, 2);
            append_utf8(random_cp(n), n);
            cut = commit_bytes.size() - n + $urandom_range(n - 1, 1);
            case ($urandom_range(2))
                0:       commit_bytes[cut] = 8'h40;
                1:       commit_bytes[cut] = 8'($urandom_range(8'h7F, 8'h00));
                default: commit_bytes[cut] = 8'($urandom_range(8'hFF, 8'hC0));
            endcase
        end else begin
            // span cut short
            n = $urandom_range(4, 2);
            append_utf8(random_cp(n), n);
            repeat ($urandom_range(n - 1, 1)) void'(commit_bytes.pop_back());
        end
    endtask

    // Queue the built commit, now and then with a stray event between its bytes.
    task automatic send_commit();
        int idx;
        int noise;
        for (idx = 0; idx < commit_bytes.size(); idx++) begin
            if (idx != 0 && $urandom_range(99) < 4) begin
                noise = $urandom_range(4);
                queue_item(1'($urandom_range(1)), noise == 0, noise == 1,
                           8'($urandom_range(255)), 1'($urandom_range(1)));
            end
            queue_text(commit_bytes[idx], idx == commit_bytes.size() - 1);
        end
        commit_bytes.delete();
    endtask

    task automatic queue_random(input int count);
        int target;
        int pick;
        target = items_queued + count;
        while (items_queued < target) begin
            pick = $urandom_range(99);
            if (pick < 7)
                queue_item(OPC_KEY, 1'b0, 1'b0, 8'($urandom_range(255)),
                           1'($urandom_range(1)));
            else if (pick < 12)
                queue_item(1'($urandom_range(1)), 1'b0, 1'b1, 8'($urandom_range(255)),
                           1'($urandom_range(1)));
            else if (pick < 15)
                queue_item(1'($urandom_range(1)), 1'b1, 1'($urandom_range(1)),
                           8'($urandom_range(255)), 1'($urandom_range(1)));
            else if (pick < 20)
                queue_text(8'($urandom_range(255)), 1'($urandom_range(1)));
            else begin
                repeat ($urandom_range(4, 1)) append_random_char();
                send_commit();
            end
        end
    endtask

    // Register writes happen only with the block idle.
    task automatic write_codes(input logic [CP_W-1:0] code_a, input logic [CP_W-1:0] code_b);
        @(negedge i_clk);
        i_cfg_we   = 1'b1;
        i_cfg_idx  = CFG_AT_CODE;
        i_cfg_data = code_a;
        @(negedge i_clk);
        i_cfg_idx  = CFG_AT_ALT;
        i_cfg_data = code_b;
        @(negedge i_clk);
        i_cfg_we   = 1'b0;
        gen_at     = code_a;
        gen_alt    = code_b;
    endtask

    // Wait for every queued item and result, then let in-flight bytes settle.
    task automatic wait_idle();
        do @(negedge i_clk);
        while (items_sent != items_queued || expected_actions.size() != 0);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    // ------------------------------------------------------------------
    // Test sequence.
    // ------------------------------------------------------------------
    initial begin
        i_rst_n            = 1'b0;
        i_cfg_we           = 1'b0;
        i_cfg_idx          = CFG_AT_CODE;
        i_cfg_data         = '0;
        in_if.valid        = 1'b0;
        in_if.opcode       = OPC_KEY;
        in_if.secure_field = 1'b0;
        in_if.composing    = 1'b0;
        in_if.text_byte    = '0;
        in_if.last_byte    = 1'b0;
        out_if.ready       = 1'b0;
        items_queued       = 0;
        items_sent         = 0;
        result_count       = 0;
        fire_count         = 0;
        error_count        = 0;
        tx_idle_pct        = 33;
        rx_idle_pct        = 65;
        repeat (RESET_CYCLES) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // Directed part at the reset codes, sender idling a third, receiver two thirds.
        write_codes(AT_CODE_RST, AT_ALT_RST);
        queue_item(OPC_KEY, 1'b0, 1'b0, 8'hFF, 1'b1);    // key event, unused fields high
        queue_text(8'h40, 1'b0);                          // "@@" in one commit fires
        queue_text(8'h40, 1'b1);
        queue_item(OPC_TEXT, 1'b0, 1'b1, 8'h40, 1'b1);   // composing: ignored, byte dropped
        queue_item(OPC_TEXT, 1'b1, 1'b1, 8'h00, 1'b0);   // secure outranks composing
        queue_text(8'hEF, 1'b0);                          // full-width at-sign, then "@"
        queue_text(8'hBC, 1'b0);
        queue_text(8'hA0, 1'b0);
        queue_text(8'h40, 1'b1);
        queue_text(8'hFF, 1'b1);                          // bad lead byte
        queue_text(8'hF4, 1'b0);                          // span cut off by the commit end
        queue_text(8'h90, 1'b1);
        queue_text(8'hE2, 1'b0);                          // bad continuation, '@' replayed
        queue_text(8'h41, 1'b0);
        queue_text(8'h40, 1'b1);
        queue_text(8'h40, 1'b1);                          // pairs with the replayed '@'
        queue_text(8'h40, 1'b0);                          // overlong NUL between at-signs
        queue_text(8'hC0, 1'b0);
        queue_text(8'h80, 1'b0);
        queue_text(8'h40, 1'b1);
        queue_text(8'hC3, 1'b0);                          // key event inside an open span
        queue_item(OPC_KEY, 1'b0, 1'b0, 8'h00, 1'b0);
        queue_text(8'hA9, 1'b1);
        queue_text(8'h00, 1'b1);                          // plain NUL commit
        wait_idle();

        // Random phase 1: extreme codes, only U+1FFFFF is an at-sign.
        write_codes(21'h1FFFFF, 21'h000000);
        queue_random(PHASE_ITEMS);
        wait_idle();

        // Random phase 2: idling swapped, U+FFFD and 'A' count, so damage can fire.
        tx_idle_pct = 65;
        rx_idle_pct = 33;
        write_codes(REPL_CP, 21'h000041);
        queue_random(PHASE_ITEMS);
        wait_idle();

        // Random phase 3: back-to-back transfers, '@' plus a random non-ASCII code.
        tx_idle_pct = 0;
        rx_idle_pct = 0;
        write_codes(AT_CODE_RST, CP_W'($urandom_range(21'h1FFFFF, 21'h80)));
        queue_random(PHASE_ITEMS);
        wait_idle();

        $display("Covered %0d input transfers and %0d results (%0d triggers) over four code",
                 items_sent, result_count, fire_count);
        $display("settings and three idling patterns; %0d mismatches.", error_count);
        if (error_count == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule
`default_nettype wire
